// ===== src/pmrd_pkg.sv =====
// Package for the power meter reply decoder: payload types, frame constants, CRC-16 step.
`default_nettype none
package pmrd_pkg;

	// Frame layout
	localparam int unsigned FRAME_LEN = 25;
	localparam int unsigned CRC_LEN   = 23;
	localparam int unsigned CAP_FIRST = 3;
	localparam int unsigned CAP_DEPTH = 20;
	localparam int unsigned POS_W     = 5;

	localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(CRC_LEN);
	localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_CRC_BAD = 2'd1;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       timeout;
	} in_t;

	typedef struct packed {
		logic [15:0] voltage_tenths;
		logic [31:0] current_milliamps;
		logic [31:0] power_tenths;
		logic [31:0] energy_wh;
		logic [15:0] frequency_tenths;
		logic [15:0] power_factor_hundredths;
	} readings_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] voltage_tenths;
		logic [31:0] current_milliamps;
		logic [31:0] power_tenths;
		logic [31:0] energy_wh;
		logic [15:0] frequency_tenths;
		logic [15:0] power_factor_hundredths;
	} out_t;

	// Frame tracker status toward the top level
	typedef struct packed {
		logic last;    // current byte closes the frame
		logic crc_ok;  // received CRC matches the running CRC
	} frame_info_t;

	// Modbus CRC-16, reflected, one byte, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== src/pmrd_frame_track.sv =====
// Frame tracker: byte position, running CRC, data byte capture and reading assembly.
`default_nettype none
module pmrd_frame_track (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire pmrd_pkg::in_t      item,
	output pmrd_pkg::frame_info_t   info,
	output pmrd_pkg::readings_t     readings
);
	import pmrd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [7:0]       cap_q [CAP_DEPTH];
	logic [7:0]       crc_lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
		end else if (step) begin
			if (item.timeout || pos_q >= POS_LAST) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (pos_q < POS_CRC_LO) begin
					crc_q <= crc16_byte(crc_q, item.rx_byte);
				end
			end
		end
	end

	// Data and CRC byte capture, no reset needed
	always_ff @(posedge clk) begin
		if (step && !item.timeout) begin
			for (int i = 0; i < CAP_DEPTH; i++) begin
				if (pos_q == POS_W'(i + CAP_FIRST)) begin
					cap_q[i] <= item.rx_byte;
				end
			end
			if (pos_q == POS_CRC_LO) begin
				crc_lo_q <= item.rx_byte;
			end
		end
	end

	assign info.last   = (pos_q >= POS_LAST);
	assign info.crc_ok = ({item.rx_byte, crc_lo_q} == crc_q);

	// Field byte order as sent by the meter
	assign readings.voltage_tenths          = {cap_q[0], cap_q[1]};
	assign readings.current_milliamps       = {cap_q[5], cap_q[4], cap_q[3], cap_q[2]};
	assign readings.power_tenths            = {cap_q[9], cap_q[8], cap_q[7], cap_q[6]};
	assign readings.energy_wh               = {cap_q[13], cap_q[12], cap_q[11], cap_q[10]};
	assign readings.frequency_tenths        = {cap_q[14], cap_q[15]};
	assign readings.power_factor_hundredths = {cap_q[16], cap_q[17]};

endmodule
`default_nettype wire

// ===== src/power_meter_reply_decoder.sv =====
// Top level of the Modbus RTU power meter reply decoder.
// Each input transaction carries one received byte of a 25-byte meter reply, or a timeout
// flag. The block runs a Modbus CRC-16 (init FFFF, reflected poly A001) over bytes 0..22 and
// checks it against bytes 23 (low) and 24 (high). Bytes 3..22 are captured as they arrive.
// Byte 24 yields one output transaction: status OK with freshly loaded readings when the CRC
// matches, otherwise status CRC_BAD with the previous readings. A timeout transaction aborts
// the frame and always yields a status TIMEOUT transaction carrying the unchanged readings.
// All other bytes yield nothing. Readings reset to zero. Throughput is one byte per clock.
// Each byte is held in the input register, and a result is loaded from there into the
// result register, which drives output valid. The only stall comes from the output: a byte
// that produces a result waits in the input register while a previous result has not been
// taken, and bytes with no result pass freely. No clearing pass is needed after reset.
`default_nettype none
module power_meter_reply_decoder (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire pmrd_pkg::in_t   in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output pmrd_pkg::out_t       out_data
);
	import pmrd_pkg::*;

	// Input stage
	logic        valid_s1;
	in_t         item_s1;

	// Result register; its reading fields double as the held readings
	logic        out_valid_q;
	out_t        out_q;

	frame_info_t info;
	readings_t   new_readings;
	logic        produces;
	logic        out_free;
	logic        advance;
	logic        in_accept;

	assign produces  = item_s1.timeout || info.last;
	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s1 && (!produces || out_free);
	assign in_ready  = !valid_s1 || advance;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_data;
		end
	end

	pmrd_frame_track u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.info     (info),
		.readings (new_readings)
	);

	// Result register: loaded when a result-producing byte advances, cleared on handoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (advance && produces) begin
			out_valid_q <= 1'b1;
			priority if (item_s1.timeout) begin
				out_q.status <= STATUS_TIMEOUT;
			end else if (info.crc_ok) begin
				out_q.status                  <= STATUS_OK;
				out_q.voltage_tenths          <= new_readings.voltage_tenths;
				out_q.current_milliamps       <= new_readings.current_milliamps;
				out_q.power_tenths            <= new_readings.power_tenths;
				out_q.energy_wh               <= new_readings.energy_wh;
				out_q.frequency_tenths        <= new_readings.frequency_tenths;
				out_q.power_factor_hundredths <= new_readings.power_factor_hundredths;
			end else begin
				out_q.status <= STATUS_CRC_BAD;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A byte that gives no result never disturbs the held readings or status
	a_quiet_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!(advance && produces)) |=> $stable(out_q))
		else $error("result register changed without a result");

	// A pending byte held back in the input stage stays there
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled input stage lost its byte");

	// A stall only happens when a result is pending and not taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (produces && out_valid_q && !out_ready))
		else $error("input stage stalled without output back-pressure");

	// Only defined status codes are presented
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STATUS_OK || out_data.status == STATUS_CRC_BAD ||
			out_data.status == STATUS_TIMEOUT))
		else $error("undefined status code on output");

endmodule
`default_nettype wire

// ===== tb/sv/pmrd_reply_checker.sv =====
// Checker for the power meter reply decoder: models frame decoding and scores every reply.
`timescale 1ns / 100ps
`default_nettype none
module pmrd_reply_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_ready,
	input  wire pmrd_pkg::in_t  in_data,
	input  wire logic           out_valid,
	input  wire logic           out_ready,
	input  wire pmrd_pkg::out_t out_data,
	output int unsigned         mismatches,
	output int unsigned         replies_due,
	output int unsigned         ok_replies,
	output int unsigned         crc_bad_replies,
	output int unsigned         timeout_replies
);
	import pmrd_pkg::*;

	localparam int unsigned SHOW_MAX = 10;

	// decoder model state
	logic [POS_W-1:0] next_pos;
	logic [15:0]      crc_acc;
	logic [7:0]       data_bytes [CAP_DEPTH];
	logic [7:0]       crc_lo;
	readings_t        meter;
	out_t             reply_q [$];

	// CRC-16, reflected, one data bit folded in per step
	function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] data);
		logic carry;
		for (int i = 0; i < 8; i++) begin
			carry = acc[0] ^ data[i];
			acc = acc >> 1;
			if (carry) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	function automatic void show_reply(input string tag, input out_t r);
		$display("  %s st=%0d V=%0d I=%0d P=%0d E=%0d F=%0d PF=%0d", tag, r.status,
			r.voltage_tenths, r.current_milliamps, r.power_tenths, r.energy_wh,
			r.frequency_tenths, r.power_factor_hundredths);
	endfunction

	// one accepted input transaction
	task automatic absorb_byte(input in_t tr);
		logic [1:0] st;
		logic       emit;
		emit = 1'b0;
		st = STATUS_OK;
		if (tr.timeout) begin
			next_pos = '0;
			crc_acc = CRC_INIT;
			st = STATUS_TIMEOUT;
			emit = 1'b1;
		end else if (next_pos < POS_CRC_LO) begin
			crc_acc = crc_fold(crc_acc, tr.rx_byte);
			if (next_pos >= CAP_FIRST) begin
				data_bytes[next_pos - CAP_FIRST] = tr.rx_byte;
			end
			next_pos++;
		end else if (next_pos == POS_CRC_LO) begin
			crc_lo = tr.rx_byte;
			next_pos++;
		end else begin
			if ({tr.rx_byte, crc_lo} == crc_acc) begin
				meter.voltage_tenths = {data_bytes[0], data_bytes[1]};
				meter.current_milliamps = {data_bytes[5], data_bytes[4], data_bytes[3],
					data_bytes[2]};
				meter.power_tenths = {data_bytes[9], data_bytes[8], data_bytes[7],
					data_bytes[6]};
				meter.energy_wh = {data_bytes[13], data_bytes[12], data_bytes[11],
					data_bytes[10]};
				meter.frequency_tenths = {data_bytes[14], data_bytes[15]};
				meter.power_factor_hundredths = {data_bytes[16], data_bytes[17]};
			end else begin
				st = STATUS_CRC_BAD;
			end
			next_pos = '0;
			crc_acc = CRC_INIT;
			emit = 1'b1;
		end
		if (emit) begin
			reply_q.push_back(out_t'({st, meter}));
		end
	endtask

	// one accepted output transaction against the oldest expectation
	task automatic score_reply(input out_t got);
		out_t  want;
		string diffs;
		diffs = "";
		if (reply_q.size() == 0) begin
			if (mismatches < SHOW_MAX) begin
				$display("%0t: reply with none outstanding", $time);
				show_reply("actual  ", got);
			end
			mismatches++;
		end else begin
			want = reply_q.pop_front();
			if (got.status !== want.status) diffs = {diffs, " status"};
			if (got.voltage_tenths !== want.voltage_tenths) diffs = {diffs, " voltage"};
			if (got.current_milliamps !== want.current_milliamps) diffs = {diffs, " current"};
			if (got.power_tenths !== want.power_tenths) diffs = {diffs, " power"};
			if (got.energy_wh !== want.energy_wh) diffs = {diffs, " energy"};
			if (got.frequency_tenths !== want.frequency_tenths) diffs = {diffs, " frequency"};
			if (got.power_factor_hundredths !== want.power_factor_hundredths) begin
				diffs = {diffs, " power_factor"};
			end
			if (diffs != "") begin
				if (mismatches < SHOW_MAX) begin
					$display("%0t: reply mismatch in%s", $time, diffs);
					show_reply("expected", want);
					show_reply("actual  ", got);
				end
				mismatches++;
			end
			case (want.status)
				STATUS_OK:      ok_replies++;
				STATUS_CRC_BAD: crc_bad_replies++;
				default:        timeout_replies++;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_pos = '0;
			crc_acc = CRC_INIT;
			crc_lo = '0;
			meter = '0;
			reply_q.delete();
			mismatches = 0;
			ok_replies = 0;
			crc_bad_replies = 0;
			timeout_replies = 0;
			replies_due <= 0;
		end else begin
			// a reply never leaves in the cycle its byte enters, so score first
			if (out_valid && out_ready) score_reply(out_data);
			if (in_valid && in_ready) absorb_byte(in_data);
			replies_due <= reply_q.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb_power_meter_reply_decoder.sv =====
// Testbench top for the power meter reply decoder: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_power_meter_reply_decoder;
	import pmrd_pkg::*;

	localparam int unsigned RANDOM_BYTES = 2000;
	localparam int unsigned NUM_PHASES   = 4;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	// drain margin after the last reply, allowing for a stalled last reply
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int          FILL_RANDOM  = -1;
	// usual reply header: address, read-input-registers, byte count
	localparam logic [23:0] REPLY_HEADER = 24'hF80414;

	// pacing per phase: none, sender gaps, receiver stalls, both
	localparam int unsigned IDLE_PCT  [NUM_PHASES] = '{0, 75, 0, 27};
	localparam int unsigned STALL_PCT [NUM_PHASES] = '{0, 0, 75, 27};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	int unsigned cycle_count = 0;

	// stimulus tallies for the summary
	int unsigned bytes_sent     = 0;
	int unsigned frames_clean   = 0;
	int unsigned frames_corrupt = 0;
	int unsigned frames_cut     = 0;
	int unsigned noise_bursts   = 0;
	int unsigned timeouts_sent  = 0;

	int unsigned mismatches;
	int unsigned replies_due;
	int unsigned ok_replies;
	int unsigned crc_bad_replies;
	int unsigned timeout_replies;

	logic [7:0] frame_buf [FRAME_LEN];

	power_meter_reply_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	pmrd_reply_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.mismatches     (mismatches),
		.replies_due    (replies_due),
		.ok_replies     (ok_replies),
		.crc_bad_replies(crc_bad_replies),
		.timeout_replies(timeout_replies)
	);

	// 20 ns clock
	initial begin
		forever #10 clk = ~clk;
	end

	// receiver: stall at the rate of the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// run watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped by watchdog after %0d cycles", cycle_count);
		$display("** power_meter_reply_decoder: FAILED **");
		$finish;
	end

	// data byte biased toward the extremes
	function automatic logic [7:0] pick_byte();
		int unsigned roll;
		roll = $urandom_range(9);
		if (roll == 0) return 8'h00;
		if (roll == 1) return 8'hFF;
		return 8'($urandom);
	endfunction

	// One input transaction. Valid stays high from one transaction to the next unless a gap
	// is drawn, so in_valid only ever gets one assignment per edge.
	task automatic send_byte(input logic [7:0] b, input logic abort);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {b, abort};
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		if (abort) timeouts_sent++;
	endtask

	// Fill frame_buf with a reply: header, 20 data bytes (constant or random), CRC low/high.
	// The CRC for stimulus comes from the package; the checker carries its own.
	task automatic build_frame(input int fill);
		logic [15:0] crc;
		crc = CRC_INIT;
		for (int i = 0; i < int'(CRC_LEN); i++) begin
			if (i < int'(CAP_FIRST)) begin
				if (fill != FILL_RANDOM || $urandom_range(3) != 0) begin
					frame_buf[i] = REPLY_HEADER[23 - 8*i -: 8];
				end else begin
					frame_buf[i] = pick_byte();
				end
			end else if (fill == FILL_RANDOM) begin
				frame_buf[i] = pick_byte();
			end else begin
				frame_buf[i] = 8'(fill);
			end
			crc = crc16_byte(crc, frame_buf[i]);
		end
		frame_buf[CRC_LEN]     = crc[7:0];
		frame_buf[CRC_LEN + 1] = crc[15:8];
	endtask

	// Send the first len bytes of frame_buf; a short frame ends in a timeout.
	task automatic send_frame(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			send_byte(frame_buf[i], 1'b0);
		end
		if (len < FRAME_LEN) begin
			send_byte(pick_byte(), 1'b1);
		end
	endtask

	// Mostly clean frames with random content; the rest is corrupted frames, frames cut
	// short by a timeout, and raw noise that a timeout then resynchronizes.
	task automatic random_sequence();
		int unsigned pick;
		int unsigned count;
		pick = $urandom_range(99);
		build_frame(FILL_RANDOM);
		if (pick < 70) begin
			send_frame(FRAME_LEN);
			frames_clean++;
		end else if (pick < 82) begin
			// any single flipped bit must fail the CRC
			frame_buf[$urandom_range(FRAME_LEN - 1)] ^= 8'(1 << $urandom_range(7));
			send_frame(FRAME_LEN);
			frames_corrupt++;
		end else if (pick < 92) begin
			send_frame($urandom_range(FRAME_LEN - 1));
			frames_cut++;
		end else begin
			count = $urandom_range(1, 30);
			for (int unsigned i = 0; i < count; i++) begin
				send_byte(8'($urandom), 1'b0);
			end
			send_byte(pick_byte(), 1'b1);
			noise_bursts++;
		end
	endtask

	initial begin
		int unsigned stop_at;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: timeout with no frame open, readings still at reset
		send_byte(8'hFF, 1'b1);
		// all-zero data with a broken CRC high byte: mismatch, readings kept
		build_frame(0);
		frame_buf[FRAME_LEN - 1] ^= 8'h80;
		send_frame(FRAME_LEN);
		frames_corrupt++;
		// all-ones data, clean: every reading at its maximum
		build_frame(8'hFF);
		send_frame(FRAME_LEN);
		frames_clean++;
		// timeout right after the header
		build_frame(FILL_RANDOM);
		send_frame(CAP_FIRST);
		frames_cut++;

		// Random traffic over the pacing phases
		for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
			idle_pct  = IDLE_PCT[ph];
			stall_pct = STALL_PCT[ph];
			stop_at   = bytes_sent + RANDOM_BYTES / NUM_PHASES;
			while (bytes_sent < stop_at) begin
				random_sequence();
			end
		end
		in_valid <= 1'b0;

		// let the reply count settle after the last transaction before reading it
		@(posedge clk);
		while (replies_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes: %0d clean frames, %0d corrupted, %0d cut short, %0d noise bursts",
			bytes_sent, frames_clean, frames_corrupt, frames_cut, noise_bursts);
		$display("Replies checked: %0d ok, %0d CRC mismatch, %0d timeout (%0d timeouts sent)",
			ok_replies, crc_bad_replies, timeout_replies, timeouts_sent);
		if (mismatches == 0 && replies_due == 0) begin
			$display("** power_meter_reply_decoder: PASSED **");
		end else begin
			$display("** power_meter_reply_decoder: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/pmrd_pkg.sv
src/pmrd_frame_track.sv
src/power_meter_reply_decoder.sv
tb/sv/pmrd_reply_checker.sv
tb/sv/tb_power_meter_reply_decoder.sv
